/* rtl/dqf_pkg.sv */
// Shared types and constants for the deque buffer with odd filter.
package dqf_pkg;

  // Default ring capacity in words
  localparam int unsigned DEPTH_DEF = 1024;

  // Fixed field widths of the beats
  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned STAT_W = 2;

  // Operation codes carried in the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ       = 3'd4,
    MODE_DROP_EVENS = 3'd5
  } mode_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_READ,
    CS_DROP,
    CS_RESULT
  } ctrl_state_e;

  // Input beat
  typedef struct packed {
    logic        [MODE_W-1:0] mode;
    logic signed [WORD_W-1:0] value;
    logic        [POS_W-1:0]  position;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic signed [WORD_W-1:0] read_data;
    logic        [CNT_W-1:0]  count;
    logic        [STAT_W-1:0] status;
  } out_item_t;

endpackage

/* rtl/deque_buffer_with_odd_filter_top.sv */
// Top level of the deque buffer with odd filter: controller, word RAM, output register.
//
//   channel | direction | handshake               | beat
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid_i/in_stall_o   | in_data_i  (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (out_item_t)
//
// Push, pop, undefined modes and out-of-range reads go from idle straight to the result
// state; an in-range read passes a read state for the registered RAM read data; drop
// evens on a nonempty ring walks it, the single RAM read port visiting one stored word per cycle.
// Reset clears head, count and control state; the word RAM is not cleared.
// A result waits in the output register under stall while the next beat is
// taken in; the controller then holds that beat's result until the register frees.
module deque_buffer_with_odd_filter_top #(
  parameter int unsigned DEPTH = dqf_pkg::DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dqf_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dqf_pkg::out_item_t  out_data_o
);

  import dqf_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);

  logic              res_valid;
  logic              res_ready;
  out_item_t         res;
  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q;

  dqf_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  dqf_ram #(
    .Width(WORD_W),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the beat payload
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // One beat at a time: an accepted beat closes the input for the next cycle
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open in the cycle after an accepted beat");

  // A failed operation never returns read data
  a_fail_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.read_data == '0)
    else $error("nonzero read data with error status");

  // An empty report comes only with a zero count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |-> out_data_o.count == '0)
    else $error("empty status with nonzero count");

endmodule

/* rtl/dqf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dqf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dqf_ctrl.sv */
// Ring pointer, count and sequencer for the deque operations and compaction.
module dqf_ctrl #(
  parameter int unsigned DEPTH = dqf_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  dqf_pkg::in_item_t        in_data_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output dqf_pkg::out_item_t       res_o,
  output logic                     ram_we_o,
  output logic [$clog2(DEPTH)-1:0] ram_waddr_o,
  output logic [dqf_pkg::WORD_W-1:0] ram_wdata_o,
  output logic                     ram_re_o,
  output logic [$clog2(DEPTH)-1:0] ram_raddr_o,
  input  logic [dqf_pkg::WORD_W-1:0] ram_rdata_i
);

  import dqf_pkg::*;

  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  localparam logic [CW:0]   DepthSum = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);
  localparam logic [PW-1:0] LastSlot = PW'(DEPTH - 1);

  ctrl_state_e      state_q, state_d;
  logic [PW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    kept_q, kept_d;
  out_item_t        res_q, res_d;
  logic             full;
  logic             empty;
  logic             pos_bad;

  // Ring slot of an offset from the head; the sum stays below twice the depth
  function automatic logic [PW-1:0] slot_of(logic [PW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = {{(CW + 1 - PW){1'b0}}, base} + {1'b0, off};
    if (sum >= DepthSum) begin
      sum = sum - DepthSum;
    end
    return sum[PW-1:0];
  endfunction

  assign full    = (count_q >= DepthCnt);
  assign empty   = (count_q == '0);
  assign pos_bad = (CMPW'(in_data_i.position) >= CMPW'(count_q));

  // State and pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      kept_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      kept_q  <= kept_d;
    end
  end

  // Pending result, payload only
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Next state, memory requests and result
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;

    unique case (state_q)
      CS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          res_d.read_data = '0;
          res_d.status    = ST_OK;
          state_d         = CS_RESULT;
          unique case (in_data_i.mode)
            MODE_PUSH_BACK: begin
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = slot_of(head_q, count_q);
                ram_wdata_o = in_data_i.value;
                count_d     = count_q + 1'b1;
              end
            end
            MODE_PUSH_FRONT: begin
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                head_d      = (head_q == '0) ? LastSlot : head_q - 1'b1;
                ram_we_o    = 1'b1;
                ram_waddr_o = head_d;
                ram_wdata_o = in_data_i.value;
                count_d     = count_q + 1'b1;
              end
            end
            MODE_POP_FRONT: begin
              if (empty) begin
                res_d.status = ST_EMPTY;
              end else begin
                head_d  = slot_of(head_q, CW'(1));
                count_d = count_q - 1'b1;
              end
            end
            MODE_POP_BACK: begin
              if (empty) begin
                res_d.status = ST_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            MODE_READ: begin
              if (pos_bad) begin
                res_d.status = ST_RANGE;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = slot_of(head_q, CW'(in_data_i.position));
                state_d     = CS_READ;
              end
            end
            MODE_DROP_EVENS: begin
              // Start the walk at the front; nothing to do when empty
              if (!empty) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = head_q;
                idx_d       = CW'(1);
                kept_d      = '0;
                state_d     = CS_DROP;
              end
            end
            default: begin
            end
          endcase
          res_d.count = CNT_W'(count_d);
        end
      end

      CS_READ: begin
        res_d.read_data = ram_rdata_i;
        state_d         = CS_RESULT;
      end

      CS_DROP: begin
        // Keep an odd word at the next kept slot, behind the read pointer
        if (ram_rdata_i[0]) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = slot_of(head_q, kept_q);
          ram_wdata_o = ram_rdata_i;
          kept_d      = kept_q + 1'b1;
        end
        // Advance the read pointer or finish the walk
        if (idx_q < count_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = slot_of(head_q, idx_q);
          idx_d       = idx_q + 1'b1;
        end else begin
          count_d     = kept_d;
          res_d.count = CNT_W'(kept_d);
          state_d     = CS_RESULT;
        end
      end

      CS_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = CS_IDLE;
        end
      end
    endcase
  end

  assign res_o = res_q;

endmodule
